// ===== rtl/lsc_pkg.sv =====
// Shared types and constants of the latency statistics collector.
package lsc_pkg;

  localparam int unsigned SampleW  = 32;
  localparam int unsigned SumW     = 64;
  localparam int unsigned MeanW    = 36;
  localparam int unsigned MedianW  = 33;
  localparam int unsigned StoredW  = 11;
  localparam int unsigned MeanFrac = 4;

  // floor(n / 100) as (n * Q100Recip) >> Q100Shift, exact for n below 2^17
  localparam int unsigned Q100RecipW = 18;
  localparam logic [Q100RecipW-1:0] Q100Recip = 18'd167773;
  localparam int unsigned Q100Shift = 24;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef logic [SampleW-1:0] sample_t;

endpackage

// ===== rtl/lsc_if.sv =====
// Handshake interfaces for the sample and result channels.
interface lsc_in_if;
  import lsc_pkg::*;
  logic    valid;
  logic    ready;
  cmd_e    command;
  sample_t sample_us;
  modport source (output valid, output command, output sample_us, input ready);
  modport sink (input valid, input command, input sample_us, output ready);
endinterface

interface lsc_out_if;
  import lsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [31:0]         sample_count;
  logic [StoredW-1:0]  stored_count;
  logic [31:0]         minimum_us;
  logic [31:0]         maximum_us;
  logic [MeanW-1:0]    mean_q4;
  logic [MedianW-1:0]  median_doubled;
  logic [31:0]         percentile_99_us;
  modport source (output valid, output sample_count, output stored_count,
                  output minimum_us, output maximum_us, output mean_q4,
                  output median_doubled, output percentile_99_us, input ready);
  modport sink (input valid, input sample_count, input stored_count,
                input minimum_us, input maximum_us, input mean_q4,
                input median_doubled, input percentile_99_us, output ready);
endinterface

// ===== rtl/lsc_cell.sv =====
// One entry of the sorted store: compare, shift from the left neighbour, read select.
module lsc_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned CW  = 11,
  parameter int unsigned AW  = 10
) (
  input  logic                   clk_i,
  input  logic                   insert_i,
  input  logic [CW-1:0]          fill_i,
  input  lsc_pkg::sample_t       sample_i,
  input  logic                   left_gt_i,
  input  lsc_pkg::sample_t       left_val_i,
  input  logic [AW-1:0]          rd_addr_i,
  output logic                   gt_o,
  output lsc_pkg::sample_t       val_o,
  output lsc_pkg::sample_t       rd_o
);
  import lsc_pkg::*;

  sample_t val_q;
  logic    occupied;
  logic    at_tail;

  assign occupied = CW'(Idx) < fill_i;
  assign at_tail  = CW'(Idx) == fill_i;
  assign gt_o     = occupied && (val_q > sample_i);
  assign val_o    = val_q;
  assign rd_o     = (rd_addr_i == AW'(Idx)) ? val_q : '0;

  always_ff @(posedge clk_i) begin
    if (insert_i && (gt_o || at_tail)) begin
      val_q <= left_gt_i ? left_val_i : sample_i;
    end
  end

endmodule

// ===== rtl/lsc_divider.sv =====
// Iterative divider for the Q.4 mean, one quotient bit per cycle, saturating.
module lsc_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lsc_pkg::SumW-1:0]  sum_i,
  input  logic [31:0]               count_i,
  output logic                      done_o,
  output logic [lsc_pkg::MeanW-1:0] mean_o
);
  import lsc_pkg::*;

  localparam int unsigned StepW = $clog2(MeanW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [32:0]      rem_q, rem_d;
  logic [MeanW-1:0] bits_q, bits_d;
  logic [31:0]      div_q, div_d;
  logic [32:0]      trial;
  logic [32:0]      diff;

  assign trial  = {rem_q[31:0], bits_q[MeanW-1]};
  assign diff   = trial - {1'b0, div_q};
  assign done_o = done_q;
  assign mean_o = bits_q;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    rem_d  = rem_q;
    bits_d = bits_q;
    div_d  = div_q;
    if (start_i) begin
      div_d  = count_i;
      step_d = StepW'(MeanW);
      if (count_i == '0) begin
        bits_d = '0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (sum_i[SumW-1:32] >= count_i) begin
        bits_d = '1;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d  = {1'b0, sum_i[SumW-1:32]};
        bits_d = {sum_i[31:0], {MeanFrac{1'b0}}};
        busy_d = 1'b1;
        done_d = 1'b0;
      end
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff;
      end else begin
        rem_d = trial;
      end
      bits_d = {bits_q[MeanW-2:0], ~diff[32]};
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    div_q  <= div_d;
  end

endmodule

// ===== rtl/latency_statistics_collector_unit.sv =====
// Top level of the latency statistics collector.
//
// in_i carries one transaction per command: add a latency sample in
// microseconds, or clear every statistic and the sorted store. For each
// transaction out_i delivers one result: count, stored count, minimum,
// maximum, Q.4 mean, doubled median and 99th percentile after the command.
// The sorted store is a row of CAPACITY cells; an insertion shifts all the
// larger entries one cell to the right together, in the S_UPDATE state.
// After acceptance a result passes these steps: insertion (S_UPDATE),
// scaling of the percentile index and start of the divider (S_IDX), the
// median and percentile reads (S_RD0 to S_RD2), which overlap the
// one-bit-per-cycle mean divider that sets the rate, a wait for the divider
// to finish (S_WAIT) and the load of the output register (S_OUT). With no
// samples counted or a saturated mean the divider finishes at once.
// A new transaction is accepted the cycle after the result is loaded, even
// while that result is held; none is taken while one is still in progress.
// If the receiver stalls with a result still held, the finished item waits
// and acceptance stops until the register frees.
// After reset the store is empty and all statistics read zero; store
// entries hold no defined value until written.
module latency_statistics_collector_unit #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsc_in_if.sink    in_i,
  lsc_out_if.source out_o
);
  import lsc_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_UPDATE, S_IDX, S_RD0, S_RD1, S_RD2, S_WAIT, S_OUT
  } state_e;

  state_e          state_q, state_d;
  cmd_e            cmd_q;
  sample_t         smp_q;
  logic [CW-1:0]   stored_q;
  logic [31:0]     count_q;
  sample_t         min_q, max_q;
  logic [SumW-1:0] sum_q;
  logic [CW-1:0]   q100_q;
  sample_t         rda_q, rdb_q, pct_q;
  logic            out_valid_q;

  logic                  insert;
  logic [AW-1:0]         rd_addr;
  sample_t               rd_data;
  logic [CAPACITY-1:0]   gt;
  sample_t               cval [CAPACITY];
  sample_t               crd  [CAPACITY];
  logic [CW+Q100RecipW-1:0] prod;
  logic [CW-1:0]         pct_idx;
  logic [SumW:0]         sum_ext;
  logic                  div_start, div_done;
  logic [MeanW-1:0]      div_mean;

  assign insert = (state_q == S_UPDATE) && (cmd_q == CMD_ADD) &&
                  (stored_q < CW'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lsc_cell #(.Idx(i), .CW(CW), .AW(AW)) u_cell (
      .clk_i     (clk_i),
      .insert_i  (insert),
      .fill_i    (stored_q),
      .sample_i  (smp_q),
      .left_gt_i ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .left_val_i((i == 0) ? smp_q : cval[(i == 0) ? 0 : i-1]),
      .rd_addr_i (rd_addr),
      .gt_o      (gt[i]),
      .val_o     (cval[i]),
      .rd_o      (crd[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | crd[i];
    end
  end

  assign prod    = {{Q100RecipW{1'b0}}, stored_q} * (CW+Q100RecipW)'(Q100Recip);
  assign pct_idx = (q100_q == '0) ? (stored_q - 1'b1) : (stored_q - q100_q);

  always_comb begin
    unique case (state_q)
      S_RD0:   rd_addr = stored_q[0] ? AW'(stored_q >> 1) : AW'((stored_q >> 1) - 1'b1);
      S_RD1:   rd_addr = AW'(stored_q >> 1);
      S_RD2:   rd_addr = AW'(pct_idx);
      default: rd_addr = '0;
    endcase
  end

  assign sum_ext   = {1'b0, sum_q} + (SumW+1)'(smp_q);
  assign div_start = (state_q == S_IDX);

  lsc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (sum_q),
    .count_i(count_q),
    .done_o (div_done),
    .mean_o (div_mean)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDX;
      S_IDX:    state_d = S_RD0;
      S_RD0:    state_d = S_RD1;
      S_RD1:    state_d = S_RD2;
      S_RD2:    state_d = S_WAIT;
      S_WAIT:   if (div_done) state_d = S_OUT;
      S_OUT:    if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stored_q    <= '0;
      count_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_UPDATE) begin
        if (cmd_q == CMD_CLEAR) begin
          stored_q <= '0;
          count_q  <= '0;
          min_q    <= '0;
          max_q    <= '0;
          sum_q    <= '0;
        end else begin
          if (insert) stored_q <= stored_q + 1'b1;
          if (count_q == '0 || smp_q < min_q) min_q <= smp_q;
          if (count_q == '0 || smp_q > max_q) max_q <= smp_q;
          if (count_q != '1) count_q <= count_q + 1'b1;
          sum_q <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
        end
      end
      if (state_q == S_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= in_i.command;
      smp_q <= in_i.sample_us;
    end
    if (state_q == S_IDX) q100_q <= CW'(prod >> Q100Shift);
    if (state_q == S_RD0) rda_q <= rd_data;
    if (state_q == S_RD1) rdb_q <= rd_data;
    if (state_q == S_RD2) pct_q <= rd_data;
    if (state_q == S_OUT && (!out_valid_q || out_o.ready)) begin
      out_o.sample_count     <= count_q;
      out_o.stored_count     <= StoredW'(stored_q);
      out_o.minimum_us       <= min_q;
      out_o.maximum_us       <= max_q;
      out_o.mean_q4          <= div_mean;
      out_o.median_doubled   <= (stored_q == '0) ? '0 :
                                ({1'b0, rda_q} + {1'b0, rdb_q});
      out_o.percentile_99_us <= (stored_q == '0) ? '0 : pct_q;
    end
  end

  assign out_o.valid = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_UPDATE)
    else $error("accepted transaction did not start an update");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CW'(CAPACITY))
    else $error("store fill beyond capacity");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> min_q <= max_q)
    else $error("minimum above maximum");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPDATE && cmd_q == CMD_CLEAR |=> stored_q == '0 && count_q == '0)
    else $error("clear left statistics behind");

endmodule
